### src/vsb_pkg.sv
// Shared constants for the vector sphere blend block.
package vsb_pkg;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam int unsigned REG_BYPASS = 0;

  // Byte address to register index shift.
  localparam int unsigned REG_ADDR_SHIFT = 2;

  // Per-stage control carried along every cell of the chains.
  typedef struct packed {
    logic valid;
  } stage_ctrl_t;

endpackage

### src/vsb_sqrt_cell.sv
// One digit cell of the pipelined integer square root chain.
module vsb_sqrt_cell #(
  parameter int W     = 24,
  parameter int STAGE = 0,
  parameter int SW    = 120
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vsb_pkg::stage_ctrl_t   ctrl_i,
  input  logic [2*W-1:0]         n_i,
  input  logic [2*W-1:0]         res_i,
  input  logic [SW-1:0]          side_i,
  output vsb_pkg::stage_ctrl_t   ctrl_o,
  output logic [2*W-1:0]         n_o,
  output logic [2*W-1:0]         res_o,
  output logic [SW-1:0]          side_o
);

  localparam logic [2*W-1:0] BIT_C = {{(2*W-1){1'b0}}, 1'b1} << (2 * (W - 1 - STAGE));

  vsb_pkg::stage_ctrl_t ctrl_q;
  logic [2*W-1:0] n_d, n_q, res_d, res_q, trial;
  logic [SW-1:0]  side_q;

  always_comb begin
    trial = res_i + BIT_C;
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + BIT_C;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    res_q  <= res_d;
    side_q <= side_i;
  end

  assign ctrl_o = ctrl_q;
  assign n_o    = n_q;
  assign res_o  = res_q;
  assign side_o = side_q;

endmodule

### src/vsb_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider, three lanes wide.
module vsb_div_cell #(
  parameter int W  = 24,
  parameter int F  = 20,
  parameter int K  = 0,
  parameter int SW = 120
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vsb_pkg::stage_ctrl_t ctrl_i,
  input  logic [W+F-1:0]       rem_i [3],
  input  logic [F:0]           q_i   [3],
  input  logic [W-1:0]         len_i,
  input  logic [SW-1:0]        side_i,
  output vsb_pkg::stage_ctrl_t ctrl_o,
  output logic [W+F-1:0]       rem_o [3],
  output logic [F:0]           q_o   [3],
  output logic [W-1:0]         len_o,
  output logic [SW-1:0]        side_o
);

  localparam logic [F:0] QBIT_C = {{F{1'b0}}, 1'b1} << K;

  vsb_pkg::stage_ctrl_t ctrl_q;
  logic [W+F:0]   trial;
  logic [W+F-1:0] rem_d [3];
  logic [W+F-1:0] rem_q [3];
  logic [F:0]     q_d   [3];
  logic [F:0]     q_q   [3];
  logic [W-1:0]   len_q;
  logic [SW-1:0]  side_q;

  assign trial = {{(F+1){1'b0}}, len_i} << K;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ({1'b0, rem_i[i]} >= trial) begin
        rem_d[i] = rem_i[i] - trial[W+F-1:0];
        q_d[i]   = q_i[i] | QBIT_C;
      end else begin
        rem_d[i] = rem_i[i];
        q_d[i]   = q_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    q_q    <= q_d;
    len_q  <= len_i;
    side_q <= side_i;
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign q_o    = q_q;
  assign len_o  = len_q;
  assign side_o = side_q;

endmodule

### src/vsb_blend.sv
// Blend toward the unit vector, scale by radius, saturate, select bypass.
module vsb_blend #(
  parameter int W = 24,
  parameter int F = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vsb_pkg::stage_ctrl_t  ctrl_i,
  input  logic signed [W-1:0]   a_i [3],
  input  logic signed [W-1:0]   t_i,
  input  logic signed [W-1:0]   r_i,
  input  logic [F:0]            q_i [3],
  input  logic [W-1:0]          len_i,
  input  logic                  bypass_i,
  output vsb_pkg::stage_ctrl_t  ctrl_o,
  output logic signed [W-1:0]   res_o [3]
);

  localparam int DW = ((W > F + 2) ? W : F + 2) + 1;
  localparam int PW = W + DW;
  localparam int MW = PW + 1;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  vsb_pkg::stage_ctrl_t c1_q, c2_q, c3_q, c4_q, c5_q;

  logic signed [W-1:0]   a1_q [3], a2_q [3], a3_q [3], a4_q [3];
  logic signed [W-1:0]   t1_q, r1_q, r2_q, r3_q;
  logic signed [F+1:0]   u    [3];
  logic signed [DW-1:0]  d_d  [3], d_q [3];
  logic signed [PW-1:0]  p_d  [3], p_q [3];
  logic signed [MW-1:0]  m_w  [3];
  logic signed [W-1:0]   m_d  [3], m_q [3];
  logic signed [2*W-1:0] mr_d [3], mr_q [3];
  logic signed [2*W-1:0] sh   [3];
  logic signed [W-1:0]   o_d  [3], o_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // unit component: signed quotient, zero for a zero-length vector
      if (len_i == '0) begin
        u[i] = '0;
      end else if (a_i[i] < 0) begin
        u[i] = -$signed({1'b0, q_i[i]});
      end else begin
        u[i] = $signed({1'b0, q_i[i]});
      end
      d_d[i] = DW'(u[i]) - DW'(a_i[i]);
      p_d[i] = PW'(t1_q) * PW'(d_q[i]);
      m_w[i] = MW'(a2_q[i]) + MW'(p_q[i] >>> F);
      if (m_w[i] > MW'(SMAX)) begin
        m_d[i] = SMAX;
      end else if (m_w[i] < MW'(SMIN)) begin
        m_d[i] = SMIN;
      end else begin
        m_d[i] = m_w[i][W-1:0];
      end
      mr_d[i] = (2*W)'(m_q[i]) * (2*W)'(r3_q);
      sh[i]   = mr_q[i] >>> F;
      if (bypass_i) begin
        o_d[i] = a4_q[i];
      end else if (sh[i] > (2*W)'(SMAX)) begin
        o_d[i] = SMAX;
      end else if (sh[i] < (2*W)'(SMIN)) begin
        o_d[i] = SMIN;
      end else begin
        o_d[i] = sh[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else begin
      c1_q <= ctrl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= a_i;
    a2_q <= a1_q;
    a3_q <= a2_q;
    a4_q <= a3_q;
    t1_q <= t_i;
    r1_q <= r_i;
    r2_q <= r1_q;
    r3_q <= r2_q;
    d_q  <= d_d;
    p_q  <= p_d;
    m_q  <= m_d;
    mr_q <= mr_d;
    o_q  <= o_d;
  end

  assign ctrl_o = c5_q;
  assign res_o  = o_q;

endmodule

### src/vector_sphere_blend.sv
// Top level: normalize a 3-D sample, blend toward the unit vector, scale by radius.
//
//   channel    | handshake                       | payload
//   -----------+---------------------------------+----------------------------------
//   request    | start, busy_o (always low)      | coord_x/y/z_i, blend_amount_i, radius_i
//   result     | result_valid_o (one-cycle pulse)| result_x/y/z_o
//   config     | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// One request is taken every clock; each result passes through the square root chain
// (one cell per result bit) and the divider chain (one cell per quotient bit), plus three
// front-end stages (capture, square, sum) and five blend stages (difference, blend multiply,
// saturate, scale multiply, output).
// Reset clears all valid flags and the bypass register; payload registers are not reset.
// The receiver cannot stall, so busy_o stays low and no request is ever held off.
module vector_sphere_blend #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int FRACTION_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy_o,
  input  logic signed [SAMPLE_WIDTH-1:0] coord_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] coord_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] coord_z_i,
  input  logic signed [SAMPLE_WIDTH-1:0] blend_amount_i,
  input  logic signed [SAMPLE_WIDTH-1:0] radius_i,
  output logic                           result_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] result_x_o,
  output logic signed [SAMPLE_WIDTH-1:0] result_y_o,
  output logic signed [SAMPLE_WIDTH-1:0] result_z_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int SW  = 5 * W;
  localparam int LAT = W + F + 9;

  // ---------------------------------------------------------------------------
  // Configuration: single bypass register
  // ---------------------------------------------------------------------------
  logic bypass_q;
  logic cfg_wr;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_hit = (32'(paddr >> vsb_pkg::REG_ADDR_SHIFT) == vsb_pkg::REG_BYPASS);
  assign prdata  = cfg_hit ? {31'b0, bypass_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b0;
    end else if (cfg_wr && cfg_hit) begin
      bypass_q <= pwdata[0];
    end
  end

  // Fully pipelined: never hold off a request.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Front end: capture request, square the magnitudes, sum them
  // ---------------------------------------------------------------------------
  vsb_pkg::stage_ctrl_t c0_q, c1_q, c2_q;
  logic signed [W-1:0] a0_q [3];
  logic signed [W-1:0] t0_q, r0_q;
  logic [SW-1:0]       side1_q, side2_q;
  logic [W-1:0]        mag   [3];
  logic [2*W-1:0]      sq_d  [3];
  logic [2*W-1:0]      sq_q  [3];
  logic [2*W-1:0]      sum_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = a0_q[i][W-1] ? W'(-a0_q[i]) : W'(a0_q[i]);
      sq_d[i] = (2*W)'(mag[i]) * (2*W)'(mag[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
      c1_q <= '0;
      c2_q <= '0;
    end else begin
      c0_q.valid <= start & ~busy_o;
      c1_q       <= c0_q;
      c2_q       <= c1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_q[0] <= coord_x_i;
    a0_q[1] <= coord_y_i;
    a0_q[2] <= coord_z_i;
    t0_q    <= blend_amount_i;
    r0_q    <= radius_i;
    sq_q    <= sq_d;
    side1_q <= {a0_q[0], a0_q[1], a0_q[2], t0_q, r0_q};
    sum_q   <= sq_q[0] + sq_q[1] + sq_q[2];
    side2_q <= side1_q;
  end

  // ---------------------------------------------------------------------------
  // Square root chain: one result bit per cell
  // ---------------------------------------------------------------------------
  vsb_pkg::stage_ctrl_t sq_ctrl [W+1];
  logic [2*W-1:0]       sq_n    [W+1];
  logic [2*W-1:0]       sq_res  [W+1];
  logic [SW-1:0]        sq_side [W+1];

  assign sq_ctrl[0] = c2_q;
  assign sq_n[0]    = sum_q;
  assign sq_res[0]  = '0;
  assign sq_side[0] = side2_q;

  for (genvar j = 0; j < W; j++) begin : g_sqrt
    vsb_sqrt_cell #(.W(W), .STAGE(j), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (sq_ctrl[j]),
      .n_i    (sq_n[j]),
      .res_i  (sq_res[j]),
      .side_i (sq_side[j]),
      .ctrl_o (sq_ctrl[j+1]),
      .n_o    (sq_n[j+1]),
      .res_o  (sq_res[j+1]),
      .side_o (sq_side[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Divider chain: |a| * 2^F / len, one quotient bit per cell, MSB first
  // ---------------------------------------------------------------------------
  vsb_pkg::stage_ctrl_t dv_ctrl [F+2];
  logic [W+F-1:0]       dv_rem  [F+2][3];
  logic [F:0]           dv_q    [F+2][3];
  logic [W-1:0]         dv_len  [F+2];
  logic [SW-1:0]        dv_side [F+2];
  logic signed [W-1:0]  sq_a    [3];

  assign sq_a[0] = sq_side[W][5*W-1:4*W];
  assign sq_a[1] = sq_side[W][4*W-1:3*W];
  assign sq_a[2] = sq_side[W][3*W-1:2*W];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = {(sq_a[i][W-1] ? W'(-sq_a[i]) : W'(sq_a[i])), {F{1'b0}}};
      dv_q[0][i]   = '0;
    end
  end

  assign dv_ctrl[0] = sq_ctrl[W];
  assign dv_len[0]  = sq_res[W][W-1:0];
  assign dv_side[0] = sq_side[W];

  for (genvar k = 0; k <= F; k++) begin : g_div
    vsb_div_cell #(.W(W), .F(F), .K(F - k), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (dv_ctrl[k]),
      .rem_i  (dv_rem[k]),
      .q_i    (dv_q[k]),
      .len_i  (dv_len[k]),
      .side_i (dv_side[k]),
      .ctrl_o (dv_ctrl[k+1]),
      .rem_o  (dv_rem[k+1]),
      .q_o    (dv_q[k+1]),
      .len_o  (dv_len[k+1]),
      .side_o (dv_side[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Blend, scale, saturate
  // ---------------------------------------------------------------------------
  logic signed [W-1:0]  bl_a [3];
  logic signed [W-1:0]  bl_res [3];
  vsb_pkg::stage_ctrl_t out_ctrl;

  assign bl_a[0] = dv_side[F+1][5*W-1:4*W];
  assign bl_a[1] = dv_side[F+1][4*W-1:3*W];
  assign bl_a[2] = dv_side[F+1][3*W-1:2*W];

  vsb_blend #(.W(W), .F(F)) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (dv_ctrl[F+1]),
    .a_i      (bl_a),
    .t_i      (dv_side[F+1][2*W-1:W]),
    .r_i      (dv_side[F+1][W-1:0]),
    .q_i      (dv_q[F+1]),
    .len_i    (dv_len[F+1]),
    .bypass_i (bypass_q),
    .ctrl_o   (out_ctrl),
    .res_o    (bl_res)
  );

  assign result_valid_o = out_ctrl.valid;
  assign result_x_o     = bl_res[0];
  assign result_y_o     = bl_res[1];
  assign result_z_o     = bl_res[2];

`ifndef SYNTH
  // Every request yields exactly one result after the fixed latency.
  a_req_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_o) |-> ##LAT result_valid_o)
    else $error("request produced no result");

  a_result_from_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy_o, LAT))
    else $error("result without request");

  // Bypass passes coordinates through unchanged.
  a_bypass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && bypass_q) |->
      (result_x_o == $past(coord_x_i, LAT)) && (result_y_o == $past(coord_y_i, LAT))
      && (result_z_o == $past(coord_z_i, LAT)))
    else $error("bypass result differs from input");

  // Zero vector gives zero result.
  a_zero_vec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !bypass_q && $past(coord_x_i == '0 && coord_y_i == '0
      && coord_z_i == '0, LAT)) |->
      (result_x_o == '0) && (result_y_o == '0) && (result_z_o == '0))
    else $error("zero vector gave nonzero result");
`endif

endmodule

### bench/vsb_checker.sv
// Checker for vector_sphere_blend: predicts each request's result and compares.
`timescale 1ns / 100ps
module vsb_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy_o,
  input  logic signed [23:0] coord_x_i,
  input  logic signed [23:0] coord_y_i,
  input  logic signed [23:0] coord_z_i,
  input  logic signed [23:0] blend_amount_i,
  input  logic signed [23:0] radius_i,
  input  logic               result_valid_o,
  input  logic signed [23:0] result_x_o,
  input  logic signed [23:0] result_y_o,
  input  logic signed [23:0] result_z_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_count
);
  import vsb_pkg::*;

  localparam int FB = 20;
  localparam longint SMAX = 64'sd8388607;
  localparam longint SMIN = -64'sd8388608;

  typedef struct {
    logic signed [23:0] x, y, z;
  } vec_t;

  vec_t sphere_q[$];
  logic bypass_q;

  function automatic longint clamp24(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  // Arithmetic shift equals floor division by 2^FB.
  function automatic longint fdiv(longint v);
    return v >>> FB;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic vec_t sphere_blend(longint a[3], longint t, longint rad, logic byp);
    vec_t o;
    longint unsigned sum, len, q, mag;
    longint u, m, res[3];
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag = (a[i] < 0) ? -a[i] : a[i];
      sum += mag * mag;
    end
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      u = 0;
      if (len != 0) begin
        mag = (a[i] < 0) ? -a[i] : a[i];
        q = (mag << FB) / len;
        u = (a[i] < 0) ? -longint'(q) : longint'(q);
      end
      m = clamp24(a[i] + fdiv(t * (u - a[i])));
      res[i] = byp ? a[i] : clamp24(fdiv(m * rad));
    end
    o.x = res[0][23:0];
    o.y = res[1][23:0];
    o.z = res[2][23:0];
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending_count = sphere_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint a[3];
    vec_t want;
    if (!rst_ni) begin
      bypass_q <= 1'b0;
      sphere_q.delete();
    end else begin
      // Check the outgoing result before queuing this edge's request.
      if (result_valid_o) begin
        if (sphere_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = sphere_q.pop_front();
          if (result_x_o !== want.x)
            report_mismatch($sformatf("x got %0d want %0d", result_x_o, want.x));
          if (result_y_o !== want.y)
            report_mismatch($sformatf("y got %0d want %0d", result_y_o, want.y));
          if (result_z_o !== want.z)
            report_mismatch($sformatf("z got %0d want %0d", result_z_o, want.z));
        end
      end
      if (start && !busy_o) begin
        a[0] = coord_x_i;
        a[1] = coord_y_i;
        a[2] = coord_z_i;
        sphere_q.push_back(sphere_blend(a, blend_amount_i, radius_i, bypass_q));
      end
      if (psel && penable && pwrite && pready && (paddr >> REG_ADDR_SHIFT) == REG_BYPASS)
        bypass_q <= pwdata[0];
    end
  end
endmodule

### bench/tb_vector_sphere_blend.sv
// Testbench top for vector_sphere_blend: stimulus, register writes and verdict.
`timescale 1ns / 100ps
module tb_vector_sphere_blend;
  import vsb_pkg::*;

  localparam int LATENCY = 54;
  localparam logic signed [23:0] ONE = 24'sd1 << 20;
  localparam logic signed [23:0] VMAX = 24'sd8388607;
  localparam logic signed [23:0] VMIN = -24'sd8388608;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy_o;
  logic signed [23:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic signed [23:0] blend_amount_i = '0, radius_i = '0;
  logic result_valid_o;
  logic signed [23:0] result_x_o, result_y_o, result_z_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending_count;

  always #10 clk_i = ~clk_i;

  vector_sphere_blend dut (.*);
  vsb_checker chk (.*);

  // Hard stop well beyond the slowest correct run.
  initial begin
    #(20 * 400000);
    $display("tb_vector_sphere_blend: errors");
    $finish;
  end

  // Drive one request on the falling edge; hold it through one accepting edge.
  task automatic send_request(logic signed [23:0] x, y, z, t, r, int gap);
    repeat (gap) @(negedge clk_i);
    coord_x_i = x;
    coord_y_i = y;
    coord_z_i = z;
    blend_amount_i = t;
    radius_i = r;
    start = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Drain every result and let the pipe run dry before a register write.
  task automatic drain_pipe();
    while (pending_count != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_bypass(logic value);
    drain_pipe();
    paddr = 3'(REG_BYPASS << REG_ADDR_SHIFT);
    pwdata = {31'd0, value};
    pwrite = 1'b1;
    psel = 1'b1;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic signed [23:0] rand_field(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 2 * ONE)) - ONE;
      default: return 24'($urandom_range(0, 4095)) - 24'sd2048;
    endcase
  endfunction

  function automatic int rand_gap();
    // Back-to-back streams half the time, random gaps otherwise.
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero vector, extremes, unit blend ends, out-of-range amounts.
    send_request(0, 0, 0, ONE, ONE, 0);
    send_request(ONE, 0, 0, ONE, ONE, 0);
    send_request(VMAX, VMAX, VMAX, ONE, ONE, 0);
    send_request(VMIN, VMIN, VMIN, ONE, ONE, 0);
    send_request(VMIN, VMAX, 0, 0, VMAX, 0);
    send_request(VMAX, VMIN, 1, VMAX, VMAX, 0);
    send_request(VMIN, VMIN, VMIN, VMIN, VMIN, 0);
    send_request(1, -1, 1, ONE >>> 1, VMIN, 0);
    send_request(-1, 0, 0, ONE, VMAX, 0);
    send_request(ONE, ONE, ONE, 0, -ONE, 0);
    send_request(24'h123456, -24'sd99, 24'sd77, VMAX, VMIN, 3);
    send_request(0, 0, 0, VMIN, VMAX, 0);

    // Bypass extremes, then back to normal.
    write_bypass(1'b1);
    send_request(VMAX, VMIN, 0, ONE, VMIN, 0);
    send_request(24'h5A5A5A, 24'hA5A5A5, -1, VMAX, VMAX, 0);
    write_bypass(1'b0);

    // Random phases, bypass on in the third phase only; mostly realistic magnitudes.
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 2) write_bypass(1'b1);
      if (phase == 3) write_bypass(1'b0);
      for (int n = 0; n < 250; n++) begin
        int mode;
        if (n == 125) drain_pipe();  // sender holds until all results are in
        mode = $urandom_range(0, 2);
        send_request(rand_field(mode), rand_field(mode), rand_field(mode),
                     rand_field($urandom_range(0, 1)), rand_field($urandom_range(0, 1)),
                     rand_gap());
      end
    end

    drain_pipe();
    if (fail_count == 0)
      $display("tb_vector_sphere_blend: clean");
    else
      $display("tb_vector_sphere_blend: errors");
    $finish;
  end
endmodule
